// ===== src/scl_pkg.sv =====
`default_nettype none

package scl_pkg;

   // Field widths fixed by the pixel format and the register map.
   localparam int PIX_W      = 4;
   localparam int BYTE_W     = 8;
   localparam int PAIR_W     = 2 * BYTE_W;
   localparam int LINE_W     = 9;
   localparam int ROWS_W     = 11;
   localparam int ROW_W      = 10;
   localparam int COL_OUT_W  = 8;

   // Configuration register map.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_ROWS = 2'd1;

   localparam logic [LINE_W-1:0] LINE_BYTES_RST = 9'd150;
   localparam logic [ROWS_W-1:0] FRAME_ROWS_RST = 11'd216;
   localparam int MIN_DIM   = 2;
   localparam int ROW_LIMIT = 1024;

   // Job queue between front and back, and the result queue.
   localparam int JQ_DEPTH  = 4;
   localparam int JQ_PTR_W  = $clog2(JQ_DEPTH);
   localparam int JQ_CNT_W  = $clog2(JQ_DEPTH + 1);
   localparam int OQ_DEPTH  = 2;
   localparam int OQ_PTR_W  = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

   typedef struct packed {
      logic [LINE_W-1:0] line_bytes;
      logic [ROWS_W-1:0] frame_rows;
   } cfg_type;

   // Operands of one result: the centre byte and its four neighbors.
   typedef struct packed {
      logic [BYTE_W-1:0]    ctr;
      logic [BYTE_W-1:0]    lft;
      logic                 has_l;
      logic [BYTE_W-1:0]    rgt;
      logic                 has_r;
      logic [BYTE_W-1:0]    abv;
      logic [BYTE_W-1:0]    blw;
      logic [COL_OUT_W-1:0] col;
      logic [ROW_W-1:0]     row;
      logic                 last;
      logic                 done;
   } res_ops_type;

   // One job carries the results released by one input word.
   typedef struct packed {
      res_ops_type first;
      res_ops_type second;
      logic        has_second;
   } job_type;

   typedef struct packed {
      logic [JQ_CNT_W-1:0] count;
      logic                not_empty;
   } jobq_status_type;

   typedef struct packed {
      logic [PAIR_W-1:0]    upper_pair;
      logic [PAIR_W-1:0]    lower_pair;
      logic [COL_OUT_W-1:0] out_column;
      logic [ROW_W-1:0]     out_row;
      logic                 last_of_run;
      logic                 frame_done;
   } rsp_type;

   // EPX rule for one pixel: {upper-left, upper-right, lower-left, lower-right}.
   function automatic logic [PAIR_W-1:0] epx_pixel(input logic [PIX_W-1:0] e,
                                                   input logic [PIX_W-1:0] b,
                                                   input logic [PIX_W-1:0] d,
                                                   input logic [PIX_W-1:0] f,
                                                   input logic [PIX_W-1:0] h);
      logic [PIX_W-1:0] e0;
      logic [PIX_W-1:0] e1;
      logic [PIX_W-1:0] e2;
      logic [PIX_W-1:0] e3;
      e0 = e;
      e1 = e;
      e2 = e;
      e3 = e;
      if (b != h && d != f) begin
         e0 = (d == b) ? d : e;
         e1 = (b == f) ? f : e;
         e2 = (d == h) ? d : e;
         e3 = (h == f) ? f : e;
      end
      return {e0, e1, e2, e3};
   endfunction

   // Scale one source byte (two pixels) into two upper and two lower bytes.
   function automatic rsp_type scale_result(input res_ops_type ops);
      logic [PIX_W-1:0]  ea;
      logic [PIX_W-1:0]  eb;
      logic [PIX_W-1:0]  dl;
      logic [PIX_W-1:0]  fr;
      logic [PAIR_W-1:0] p0;
      logic [PAIR_W-1:0] p1;
      rsp_type           res;
      ea = ops.ctr[BYTE_W-1 -: PIX_W];
      eb = ops.ctr[PIX_W-1:0];
      dl = ops.has_l ? ops.lft[PIX_W-1:0] : ea;
      fr = ops.has_r ? ops.rgt[BYTE_W-1 -: PIX_W] : eb;
      p0 = epx_pixel(ea, ops.abv[BYTE_W-1 -: PIX_W], dl, eb, ops.blw[BYTE_W-1 -: PIX_W]);
      p1 = epx_pixel(eb, ops.abv[PIX_W-1:0], ea, fr, ops.blw[PIX_W-1:0]);
      res.upper_pair  = {p0[PAIR_W-1 -: BYTE_W], p1[PAIR_W-1 -: BYTE_W]};
      res.lower_pair  = {p0[BYTE_W-1:0], p1[BYTE_W-1:0]};
      res.out_column  = ops.col;
      res.out_row     = ops.row;
      res.last_of_run = ops.last;
      res.frame_done  = ops.done;
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== src/scl_front.sv =====
`default_nettype none

module scl_front import scl_pkg::*; #(
   parameter int MAX_LINE_BYTES = 256
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cfg_type         cfg,
   input  wire logic            push,
   output logic                 full,
   input  wire logic            kind,
   input  wire logic [BYTE_W-1:0] pixel_pair,
   input  wire jobq_status_type jq_status,
   output logic                 job_push,
   output job_type              job
);

   localparam int AW    = $clog2(MAX_LINE_BYTES);
   localparam int CW    = AW + 1;
   localparam int XW    = (CW > LINE_W) ? CW : LINE_W;
   localparam int OCC_W = JQ_CNT_W + 1;

   // Input position and drain state.
   logic [AW-1:0]    col_ff;
   logic [AW-1:0]    col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [AW-1:0]    drain_ff;
   logic [AW-1:0]    drain_in;
   logic             draining_ff;
   logic             draining_in;

   // Second stage: memory data arrives here and the job is built.
   logic             f1_pix_ff;
   logic             f1_drain_ff;
   logic [AW-1:0]    f1_addr_ff;
   logic [BYTE_W-1:0] f1_v_ff;
   logic [ROW_W-1:0] f1_row_ff;
   logic             f1_endrow_ff;
   logic             f1_fin_ff;

   // Line stores: each entry holds {row above, centre row} of one column.
   logic [PAIR_W-1:0] line_mem_ff [MAX_LINE_BYTES];
   logic [PAIR_W-1:0] rd_a_ff;
   logic [BYTE_W-1:0] rd_b_ff;
   logic              fwd_a_ff;
   logic              fwd_b_ff;
   logic [PAIR_W-1:0] fwd_data_ff;

   // Window of neighbor bytes and the previous drained centre byte.
   logic [BYTE_W-1:0] w_above_ff;
   logic [BYTE_W-1:0] w_left_ff;
   logic [BYTE_W-1:0] w_mid_ff;
   logic [BYTE_W-1:0] w_below_ff;
   logic [BYTE_W-1:0] dleft_ff;

   logic [XW-1:0]     lb_x;
   logic [XW-1:0]     cols_x;
   logic [AW-1:0]     lastc;
   logic [ROWS_W-1:0] rows_eff;
   logic [ROWS_W-1:0] row_next;
   logic              accept;
   logic              pix_acc;
   logic              drain_acc;
   logic              endrow;
   logic              fin;
   logic [AW-1:0]     addr_a;
   logic [CW-1:0]     next_d;
   logic [AW-1:0]     addr_b;
   logic [OCC_W-1:0]  occupancy;

   logic [PAIR_W-1:0] ent_a;
   logic [BYTE_W-1:0] above_b;
   logic [BYTE_W-1:0] cent_c;
   logic [BYTE_W-1:0] cent_r;
   logic [PAIR_W-1:0] wr_data;
   logic [AW-1:0]     k_m1;
   logic [ROW_W-1:0]  row_m1;
   logic              top_row;
   logic              r0_en;
   logic              r1_en;
   res_ops_type       r0_ops;
   res_ops_type       r1_ops;
   res_ops_type       dr_ops;

   // Effective line length and frame height, clamped to the legal range.
   always_comb begin
      lb_x = XW'(cfg.line_bytes);
      if (lb_x < XW'(MIN_DIM)) begin
         cols_x = XW'(MIN_DIM);
      end else if (lb_x > XW'(MAX_LINE_BYTES)) begin
         cols_x = XW'(MAX_LINE_BYTES);
      end else begin
         cols_x = lb_x;
      end
      lastc = AW'(cols_x - XW'(1));
      if (cfg.frame_rows < ROWS_W'(MIN_DIM)) begin
         rows_eff = ROWS_W'(MIN_DIM);
      end else if (cfg.frame_rows > ROWS_W'(ROW_LIMIT)) begin
         rows_eff = ROWS_W'(ROW_LIMIT);
      end else begin
         rows_eff = cfg.frame_rows;
      end
   end

   // Hold off new words while the job queue plus the stage in flight could overflow.
   assign occupancy = {1'b0, jq_status.count} + OCC_W'(f1_pix_ff | f1_drain_ff);
   assign full      = occupancy >= OCC_W'(JQ_DEPTH);

   // Classify the incoming word: pixel bytes while filling, ticks while draining.
   assign accept    = push && !full;
   assign pix_acc   = accept && !kind && !draining_ff;
   assign drain_acc = accept && kind && draining_ff;
   assign endrow    = col_ff >= lastc;
   assign fin       = drain_ff >= lastc;
   assign row_next  = ROWS_W'(row_ff) + ROWS_W'(1);

   // Position counters.
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      drain_in    = drain_ff;
      draining_in = draining_ff;
      if (pix_acc) begin
         if (endrow) begin
            col_in = '0;
            row_in = row_next[ROW_W-1:0];
            if (row_next >= rows_eff) begin
               draining_in = 1'b1;
               drain_in    = '0;
            end
         end else begin
            col_in = col_ff + AW'(1);
         end
      end else if (drain_acc) begin
         if (fin) begin
            drain_in    = '0;
            col_in      = '0;
            row_in      = '0;
            draining_in = 1'b0;
         end else begin
            drain_in = drain_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         drain_ff    <= '0;
         draining_ff <= 1'b0;
         f1_pix_ff   <= 1'b0;
         f1_drain_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         drain_ff    <= drain_in;
         draining_ff <= draining_in;
         f1_pix_ff   <= pix_acc;
         f1_drain_ff <= drain_acc;
      end
   end

   // Read addresses: the current column, and the column right of a drain tick.
   assign addr_a = draining_ff ? drain_ff : col_ff;
   assign next_d = {1'b0, drain_ff} + CW'(1);
   assign addr_b = (next_d > CW'(MAX_LINE_BYTES - 1)) ? AW'(MAX_LINE_BYTES - 1)
                                                      : next_d[AW-1:0];

   // Stage payload.
   always_ff @(posedge clock) begin
      f1_addr_ff   <= addr_a;
      f1_v_ff      <= pixel_pair;
      f1_row_ff    <= row_ff;
      f1_endrow_ff <= endrow;
      f1_fin_ff    <= fin;
   end

   // Current entry, with the write of the previous word forwarded.
   assign ent_a   = fwd_a_ff ? fwd_data_ff : rd_a_ff;
   assign above_b = ent_a[PAIR_W-1 -: BYTE_W];
   assign cent_c  = ent_a[BYTE_W-1:0];
   assign cent_r  = fwd_b_ff ? fwd_data_ff[BYTE_W-1:0] : rd_b_ff;
   assign wr_data = {cent_c, f1_v_ff};

   // Line store: the centre byte moves to the row above, the new byte becomes centre.
   always_ff @(posedge clock) begin
      rd_a_ff     <= line_mem_ff[addr_a];
      rd_b_ff     <= line_mem_ff[addr_b][BYTE_W-1:0];
      fwd_a_ff    <= f1_pix_ff && (f1_addr_ff == addr_a);
      fwd_b_ff    <= f1_pix_ff && (f1_addr_ff == addr_b);
      fwd_data_ff <= wr_data;
      if (f1_pix_ff) begin
         line_mem_ff[f1_addr_ff] <= wr_data;
      end
   end

   // Neighbor window, shifted once per pixel byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         w_above_ff <= '0;
         w_left_ff  <= '0;
         w_mid_ff   <= '0;
         w_below_ff <= '0;
      end else if (f1_pix_ff) begin
         w_above_ff <= above_b;
         w_left_ff  <= w_mid_ff;
         w_mid_ff   <= cent_c;
         w_below_ff <= f1_v_ff;
      end
   end

   // Each drain tick keeps its centre byte as the left neighbor of the next.
   always_ff @(posedge clock) begin
      if (f1_drain_ff) begin
         dleft_ff <= cent_c;
      end
   end

   // Build the job for the word in the second stage.
   assign k_m1    = f1_addr_ff - AW'(1);
   assign row_m1  = f1_row_ff - ROW_W'(1);
   assign top_row = f1_row_ff == ROW_W'(1);
   assign r0_en   = f1_pix_ff && (f1_row_ff != '0) && (f1_addr_ff != '0);
   assign r1_en   = f1_pix_ff && (f1_row_ff != '0) && f1_endrow_ff;

   always_comb begin
      // Byte left of the current column, in the row above the incoming one.
      r0_ops.ctr   = w_mid_ff;
      r0_ops.lft   = w_left_ff;
      r0_ops.has_l = f1_addr_ff > AW'(1);
      r0_ops.rgt   = cent_c;
      r0_ops.has_r = 1'b1;
      r0_ops.abv   = top_row ? w_mid_ff : w_above_ff;
      r0_ops.blw   = w_below_ff;
      r0_ops.col   = COL_OUT_W'(k_m1);
      r0_ops.row   = row_m1;
      r0_ops.last  = !f1_endrow_ff;
      r0_ops.done  = 1'b0;

      // Last column of that row, released by the final byte of a line.
      r1_ops.ctr   = cent_c;
      r1_ops.lft   = w_mid_ff;
      r1_ops.has_l = f1_addr_ff != '0;
      r1_ops.rgt   = '0;
      r1_ops.has_r = 1'b0;
      r1_ops.abv   = top_row ? cent_c : above_b;
      r1_ops.blw   = f1_v_ff;
      r1_ops.col   = COL_OUT_W'(f1_addr_ff);
      r1_ops.row   = row_m1;
      r1_ops.last  = 1'b1;
      r1_ops.done  = 1'b0;

      // Bottom row during the drain: the centre byte stands in for the row below.
      dr_ops.ctr   = cent_c;
      dr_ops.lft   = dleft_ff;
      dr_ops.has_l = f1_addr_ff != '0;
      dr_ops.rgt   = cent_r;
      dr_ops.has_r = !f1_fin_ff;
      dr_ops.abv   = above_b;
      dr_ops.blw   = cent_c;
      dr_ops.col   = COL_OUT_W'(f1_addr_ff);
      dr_ops.row   = row_m1;
      dr_ops.last  = 1'b1;
      dr_ops.done  = f1_fin_ff;

      job_push       = f1_drain_ff || r0_en || r1_en;
      job.first      = f1_drain_ff ? dr_ops : (r0_en ? r0_ops : r1_ops);
      job.second     = r1_ops;
      job.has_second = !f1_drain_ff && r0_en && r1_en;
   end

   // The column counter is parked at zero for the whole drain.
   a_drain_col_zero: assert property (@(posedge clock) disable iff (reset)
      draining_ff |-> (col_ff == '0))
      else $error("column counter moved while draining");

endmodule

`default_nettype wire

// ===== src/scl_jobq.sv =====
`default_nettype none

module scl_jobq import scl_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire job_type         push_job,
   input  wire logic            pop,
   output job_type              head,
   output jobq_status_type      status
);

   job_type             entries_ff [JQ_DEPTH];
   logic [JQ_PTR_W-1:0] wr_ptr_ff;
   logic [JQ_PTR_W-1:0] rd_ptr_ff;
   logic [JQ_CNT_W-1:0] count_ff;
   logic [JQ_CNT_W-1:0] count_in;

   assign head             = entries_ff[rd_ptr_ff];
   assign status.count     = count_ff;
   assign status.not_empty = count_ff != '0;
   assign count_in         = count_ff + JQ_CNT_W'(push) - JQ_CNT_W'(pop);

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + JQ_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + JQ_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end

   // Job storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

   // The front's credit check must keep a slot free for every job it pushes.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> ((count_ff < JQ_CNT_W'(JQ_DEPTH)) || pop))
      else $error("job queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("job queue underflow");

endmodule

`default_nettype wire

// ===== src/scl_back.sv =====
`default_nettype none

module scl_back import scl_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire job_type         head,
   input  wire jobq_status_type jq_status,
   output logic                 job_pop,
   input  wire logic            pop,
   output logic                 empty,
   output rsp_type              rsp
);

   rsp_type             oq_ff [OQ_DEPTH];
   logic [OQ_PTR_W-1:0] oq_wr_ff;
   logic [OQ_PTR_W-1:0] oq_rd_ff;
   logic [OQ_CNT_W-1:0] oq_cnt_ff;
   logic [OQ_CNT_W-1:0] oq_cnt_in;
   logic                sub_ff;
   logic                sub_in;
   logic                produce;
   logic                take;
   res_ops_type         sel_ops;
   rsp_type             res;

   // One result per cycle from the head job while the result queue has room.
   assign produce = jq_status.not_empty && (oq_cnt_ff != OQ_CNT_W'(OQ_DEPTH));
   assign sel_ops = sub_ff ? head.second : head.first;
   assign res     = scale_result(sel_ops);
   assign job_pop = produce && (sub_ff || !head.has_second);
   assign sub_in  = produce ? (!sub_ff && head.has_second) : sub_ff;

   // Result queue toward the consumer.
   assign take      = pop && (oq_cnt_ff != '0);
   assign empty     = oq_cnt_ff == '0;
   assign rsp       = oq_ff[oq_rd_ff];
   assign oq_cnt_in = oq_cnt_ff + OQ_CNT_W'(produce) - OQ_CNT_W'(take);

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
         sub_ff    <= 1'b0;
      end else begin
         if (produce) begin
            oq_wr_ff <= oq_wr_ff + OQ_PTR_W'(1);
         end
         if (take) begin
            oq_rd_ff <= oq_rd_ff + OQ_PTR_W'(1);
         end
         oq_cnt_ff <= oq_cnt_in;
         sub_ff    <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (produce) begin
         oq_ff[oq_wr_ff] <= res;
      end
   end

   // The second half of a job is only pending while that job is still at the head.
   a_sub_has_job: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> (jq_status.not_empty && head.has_second))
      else $error("second result pending without a two-result job");

   a_result_shows: assert property (@(posedge clock) disable iff (reset)
      produce |=> !empty)
      else $error("produced result did not reach the result queue");

endmodule

`default_nettype wire

// ===== src/scale2x_packed_nibble_upscaler.sv =====
`default_nettype none

// Scale2x upscaler for 4-bit pixels packed two per byte, fed in raster order.
// Input channel: push/full carries one word per accepted edge, either a pixel
// byte (req_kind 0) or a drain tick (req_kind 1) sent once per column after
// the last byte of the frame. Result channel: empty/pop; each word holds the
// two upper and two lower destination bytes of one source byte and its place.
// The result for source byte (row y, column c) is released by byte (y+1, c+1),
// or by the last byte of row y+1 for the last column, or by a drain tick for
// the bottom row; it passes through the second stage, the job queue and the
// result queue before it reaches the result ports. Throughput is one input
// word per clock while full is low: each word reads the line store at two
// addresses and writes it at most once. The last byte of a line releases two
// results; the back end emits them one after the other from the same job and
// the four-entry job queue absorbs the extra one. The config port (valid/ready,
// always ready) may only be written while the block is idle. Reset restores
// line_bytes 150 and frame_rows 216, empties both queues and restarts at
// row 0; line stores are not cleared. When the receiver stops popping, the
// two-entry result queue fills, then the job queue, and then full rises.

module scale2x_packed_nibble_upscaler import scl_pkg::*; #(
   parameter int MAX_LINE_BYTES = 256
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire logic                  req_kind,
   input  wire logic [BYTE_W-1:0]     req_pixel_pair,
   output logic                       empty,
   input  wire logic                  pop,
   output logic [PAIR_W-1:0]          rsp_upper_pair,
   output logic [PAIR_W-1:0]          rsp_lower_pair,
   output logic [COL_OUT_W-1:0]       rsp_out_column,
   output logic [ROW_W-1:0]           rsp_out_row,
   output logic                       rsp_last_of_run,
   output logic                       rsp_frame_done,
   input  wire logic                  valid,
   output logic                       ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic [LINE_W-1:0] line_bytes_ff;
   logic [ROWS_W-1:0] frame_rows_ff;
   cfg_type           cfg;
   logic              job_push;
   job_type           job;
   logic              job_pop;
   job_type           job_head;
   jobq_status_type   jq_status;
   rsp_type           rsp;

   // Configuration registers.
   assign ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_bytes_ff <= LINE_BYTES_RST;
         frame_rows_ff <= FRAME_ROWS_RST;
      end else if (valid && ready) begin
         case (csr_index)
            CSR_LINE_BYTES: begin
               line_bytes_ff <= csr_data[LINE_W-1:0];
            end
            CSR_FRAME_ROWS: begin
               frame_rows_ff <= csr_data[ROWS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.line_bytes = line_bytes_ff;
   assign cfg.frame_rows = frame_rows_ff;

   // Front end: position tracking, line stores, neighbor window.
   scl_front #(
      .MAX_LINE_BYTES(MAX_LINE_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .push       (push),
      .full       (full),
      .kind       (req_kind),
      .pixel_pair (req_pixel_pair),
      .jq_status  (jq_status),
      .job_push   (job_push),
      .job        (job)
   );

   // Jobs waiting for the back end.
   scl_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (job_pop),
      .head     (job_head),
      .status   (jq_status)
   );

   // Back end: EPX per pixel and the result queue.
   scl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (job_head),
      .jq_status (jq_status),
      .job_pop   (job_pop),
      .pop       (pop),
      .empty     (empty),
      .rsp       (rsp)
   );

   assign rsp_upper_pair  = rsp.upper_pair;
   assign rsp_lower_pair  = rsp.lower_pair;
   assign rsp_out_column  = rsp.out_column;
   assign rsp_out_row     = rsp.out_row;
   assign rsp_last_of_run = rsp.last_of_run;
   assign rsp_frame_done  = rsp.frame_done;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import scl_pkg::*;

   localparam int LINE_CAP      = 256;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 40;
   localparam int RANDOM_WORDS  = 80;
   localparam int NARROW_ROWS   = 24;
   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_DRAIN  = 1'b1;
   // Index 3 maps to no register; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef enum {POP_ALWAYS, POP_HALF, POP_SPARSE} pop_style_type;

   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   logic                  req_kind;
   logic [BYTE_W-1:0]     req_pixel_pair;
   logic                  empty;
   logic                  pop;
   logic [PAIR_W-1:0]     rsp_upper_pair;
   logic [PAIR_W-1:0]     rsp_lower_pair;
   logic [COL_OUT_W-1:0]  rsp_out_column;
   logic [ROW_W-1:0]      rsp_out_row;
   logic                  rsp_last_of_run;
   logic                  rsp_frame_done;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Predicted scaled blocks, oldest first.
   rsp_type due_blocks[$];
   int      err_count;

   // Predictor copy of the registers, line stores, window and position.
   logic [LINE_W-1:0] cfg_line;
   logic [ROWS_W-1:0] cfg_rows;
   logic [7:0]        above_mem [0:LINE_CAP-1];
   logic [7:0]        centre_mem [0:LINE_CAP-1];
   logic [7:0]        win_above;
   logic [7:0]        win_left;
   logic [7:0]        win_mid;
   logic [7:0]        win_below;
   int                in_col;
   int                in_row;
   int                drain_col;
   bit                draining;

   // Sender pacing, receiver hold-off request and stimulus bookkeeping.
   int         burst_left;
   bit         steady;
   int         hold_req;
   int         frame_words;
   logic [3:0] palette [0:2];

   scale2x_packed_nibble_upscaler #(.MAX_LINE_BYTES(LINE_CAP)) u_dut (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Run limit, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int eff_cols();
      int n;
      n = int'(cfg_line);
      if (n < MIN_DIM) n = MIN_DIM;
      if (n > LINE_CAP) n = LINE_CAP;
      return n;
   endfunction

   function automatic int eff_rows();
      int n;
      n = int'(cfg_rows);
      if (n < MIN_DIM) n = MIN_DIM;
      if (n > ROW_LIMIT) n = ROW_LIMIT;
      return n;
   endfunction

   function automatic int clip_idx(input int i);
      return (i < LINE_CAP) ? i : LINE_CAP - 1;
   endfunction

   // EPX rule for one pixel: {upper-left, upper-right, lower-left, lower-right}.
   function automatic logic [15:0] epx_quad(input logic [3:0] e, input logic [3:0] b,
                                            input logic [3:0] d, input logic [3:0] f,
                                            input logic [3:0] h);
      logic [3:0] q0;
      logic [3:0] q1;
      logic [3:0] q2;
      logic [3:0] q3;
      q0 = e;
      q1 = e;
      q2 = e;
      q3 = e;
      if (b != h && d != f) begin
         q0 = (d == b) ? d : e;
         q1 = (b == f) ? f : e;
         q2 = (d == h) ? d : e;
         q3 = (h == f) ? f : e;
      end
      return {q0, q1, q2, q3};
   endfunction

   // Scale one source byte given its neighbors; missing sides repeat the centre.
   function automatic rsp_type make_block(input logic [7:0] ctr, input logic [7:0] lft,
                                          input bit has_l, input logic [7:0] rgt,
                                          input bit has_r, input logic [7:0] abv,
                                          input logic [7:0] blw, input int col,
                                          input int row, input bit last, input bit done);
      logic [3:0]  ea;
      logic [3:0]  eb;
      logic [3:0]  dl;
      logic [3:0]  fr;
      logic [15:0] p0;
      logic [15:0] p1;
      rsp_type     blk;
      ea = ctr[7:4];
      eb = ctr[3:0];
      dl = has_l ? lft[3:0] : ea;
      fr = has_r ? rgt[7:4] : eb;
      p0 = epx_quad(ea, abv[7:4], dl, eb, blw[7:4]);
      p1 = epx_quad(eb, abv[3:0], ea, fr, blw[3:0]);
      blk.upper_pair  = {p0[15:8], p1[15:8]};
      blk.lower_pair  = {p0[7:0], p1[7:0]};
      blk.out_column  = col[COL_OUT_W-1:0];
      blk.out_row     = row[ROW_W-1:0];
      blk.last_of_run = last;
      blk.frame_done  = done;
      return blk;
   endfunction

   // Advance the predictor by one accepted word and queue the blocks it releases.
   task automatic upscale_word(input logic kind, input logic [7:0] pair);
      int         lastc;
      int         k;
      int         idx;
      int         d;
      logic [7:0] above_b;
      logic [7:0] centre_b;
      logic [7:0] lft;
      logic [7:0] rgt;
      bit         fin;
      bit         endrow;
      lastc = eff_cols() - 1;
      if (kind == KIND_DRAIN) begin
         if (!draining) return;
         d = drain_col;
         fin = (d >= lastc);
         centre_b = centre_mem[clip_idx(d)];
         lft = (d >= 1) ? centre_mem[clip_idx(d - 1)] : 8'h00;
         rgt = fin ? 8'h00 : centre_mem[clip_idx(d + 1)];
         above_b = above_mem[clip_idx(d)];
         due_blocks.push_back(make_block(centre_b, lft, d >= 1, rgt, !fin, above_b,
                                         centre_b, d, in_row - 1, 1'b1, fin));
         if (fin) begin
            drain_col = 0;
            in_col = 0;
            in_row = 0;
            draining = 1'b0;
         end else begin
            drain_col = d + 1;
         end
         return;
      end
      if (draining) return;
      k = in_col;
      idx = clip_idx(k);
      above_b = above_mem[idx];
      centre_b = centre_mem[idx];
      endrow = (k >= lastc);
      above_mem[idx] = centre_b;
      centre_mem[idx] = pair;
      // The byte to the left of this column, one row up, is now complete.
      if (in_row >= 1 && k >= 1)
         due_blocks.push_back(make_block(win_mid, win_left, k >= 2, centre_b, 1'b1,
                                         (in_row == 1) ? win_mid : win_above, win_below,
                                         k - 1, in_row - 1, !endrow, 1'b0));
      // The end of a row also releases the last column of the row above.
      if (in_row >= 1 && endrow)
         due_blocks.push_back(make_block(centre_b, win_mid, k >= 1, 8'h00, 1'b0,
                                         (in_row == 1) ? centre_b : above_b, pair,
                                         k, in_row - 1, 1'b1, 1'b0));
      win_left = win_mid;
      win_mid = centre_b;
      win_above = above_b;
      win_below = pair;
      if (endrow) begin
         in_col = 0;
         in_row = in_row + 1;
         if (in_row >= eff_rows()) begin
            draining = 1'b1;
            drain_col = 0;
         end
      end else begin
         in_col = k + 1;
      end
   endtask

   task automatic sender_idle();
      @(negedge clock);
      push = 1'b0;
   endtask

   // Offer one word in bursts with random gaps, and predict once it is taken.
   task automatic send_word(input logic kind, input logic [7:0] pair);
      int gap;
      if (burst_left == 0) begin
         gap = steady ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            sender_idle();
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      push = 1'b1;
      req_kind = kind;
      req_pixel_pair = pair;
      @(posedge clock);
      while (full) @(posedge clock);
      upscale_word(kind, pair);
   endtask

   // Stop sending until every predicted block has come out, then let the pipe settle.
   task automatic wait_drained();
      sender_idle();
      while (due_blocks.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      @(negedge clock);
      valid = 1'b1;
      csr_index = idx;
      csr_data = data;
      @(posedge clock);
      while (!ready) @(posedge clock);
      case (idx)
         CSR_LINE_BYTES: cfg_line = data[LINE_W-1:0];
         CSR_FRAME_ROWS: cfg_rows = data[ROWS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      valid = 1'b0;
   endtask

   task automatic pick_palette();
      for (int i = 0; i < 3; i++) palette[i] = 4'($urandom_range(0, 15));
   endtask

   // Mostly a three-color palette so the EPX equalities fire often.
   function automatic logic [7:0] next_pair();
      if ($urandom_range(0, 6) == 0) return 8'($urandom_range(0, 255));
      return {palette[$urandom_range(0, 2)], palette[$urandom_range(0, 2)]};
   endfunction

   // One whole frame; when noisy, stray drain ticks and late bytes are mixed in.
   task automatic send_frame(input int rows, input int cols, input bit noisy);
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < cols; c++) begin
            if (noisy && $urandom_range(0, 19) == 0)
               send_word(KIND_DRAIN, 8'($urandom_range(0, 255)));
            send_word(KIND_PIXEL, next_pair());
            frame_words++;
         end
      end
      for (int c = 0; c < cols; c++) begin
         if (noisy && $urandom_range(0, 9) == 0)
            send_word(KIND_PIXEL, 8'($urandom_range(0, 255)));
         send_word(KIND_DRAIN, 8'($urandom_range(0, 255)));
         frame_words++;
      end
   endtask

   // Small frames with extreme bytes, ignored words and unmapped register writes.
   task automatic test_directed();
      write_reg(CSR_LINE_BYTES, 11'd3);
      write_reg(CSR_FRAME_ROWS, 11'd3);
      write_reg(CSR_UNMAPPED, 11'h7FF);
      send_word(KIND_DRAIN, 8'hA5);
      send_word(KIND_PIXEL, 8'h00);
      send_word(KIND_PIXEL, 8'hFF);
      send_word(KIND_PIXEL, 8'h0F);
      send_word(KIND_PIXEL, 8'hF0);
      send_word(KIND_PIXEL, 8'h11);
      send_word(KIND_PIXEL, 8'h22);
      send_word(KIND_DRAIN, 8'h5A);
      send_word(KIND_PIXEL, 8'h12);
      send_word(KIND_PIXEL, 8'h21);
      send_word(KIND_PIXEL, 8'hFF);
      send_word(KIND_DRAIN, 8'h00);
      send_word(KIND_PIXEL, 8'h77);
      send_word(KIND_DRAIN, 8'hFF);
      send_word(KIND_DRAIN, 8'h00);
      // Checkerboard so every corner rule of EPX fires.
      write_reg(CSR_LINE_BYTES, 11'd2);
      write_reg(CSR_FRAME_ROWS, 11'd2);
      send_word(KIND_PIXEL, 8'h12);
      send_word(KIND_PIXEL, 8'h21);
      send_word(KIND_PIXEL, 8'h21);
      send_word(KIND_PIXEL, 8'h12);
      send_word(KIND_DRAIN, 8'h00);
      send_word(KIND_DRAIN, 8'h00);
   endtask

   // Widest line: an oversized setting clamps to the full store, rows clamp to two.
   task automatic test_wide_line();
      write_reg(CSR_LINE_BYTES, 11'h7FF);
      write_reg(CSR_FRAME_ROWS, 11'd1);
      pick_palette();
      send_frame(MIN_DIM, LINE_CAP, 1'b0);
   endtask

   // Narrow, taller frame: a zero line width clamps to two columns.
   task automatic test_tall_frame();
      write_reg(CSR_LINE_BYTES, 11'd0);
      write_reg(CSR_FRAME_ROWS, CSR_DATA_W'(NARROW_ROWS));
      pick_palette();
      send_frame(NARROW_ROWS, MIN_DIM, 1'b0);
   endtask

   // Shrink both registers partway through a frame; the next byte ends the row
   // and the frame at once.
   task automatic test_mid_frame_change();
      write_reg(CSR_LINE_BYTES, 11'd6);
      write_reg(CSR_FRAME_ROWS, 11'd50);
      pick_palette();
      for (int i = 0; i < 16; i++) send_word(KIND_PIXEL, next_pair());
      write_reg(CSR_LINE_BYTES, 11'd3);
      write_reg(CSR_FRAME_ROWS, 11'd3);
      send_word(KIND_PIXEL, next_pair());
      for (int i = 0; i < 3; i++) send_word(KIND_DRAIN, 8'h00);
   endtask

   // Receiver holds off while the sender keeps offering, so full must rise.
   task automatic test_full_stall();
      write_reg(CSR_LINE_BYTES, 11'd4);
      write_reg(CSR_FRAME_ROWS, 11'd8);
      pick_palette();
      steady = 1'b1;
      hold_req = 200;
      send_frame(8, 4, 1'b0);
      steady = 1'b0;
      wait_drained();
   endtask

   // Random frame sizes and content, mostly small, with noise words mixed in.
   task automatic test_random_frames();
      int start;
      int cols;
      int rows;
      start = frame_words;
      while (frame_words - start < RANDOM_WORDS) begin
         cols = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(2, 8);
         rows = $urandom_range(2, 6);
         write_reg(CSR_LINE_BYTES, CSR_DATA_W'(cols));
         write_reg(CSR_FRAME_ROWS, CSR_DATA_W'(rows));
         pick_palette();
         steady = ($urandom_range(0, 3) == 0);
         send_frame(rows, cols, 1'b1);
      end
      steady = 1'b0;
   endtask

   // Receiver: random stall styles in phases, plus any requested long hold-off.
   initial begin : receiver
      int            phase_left;
      int            hold_left;
      pop_style_type style;
      pop = 1'b0;
      phase_left = 0;
      hold_left = 0;
      style = POP_ALWAYS;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
         end
         if (hold_left > 0) begin
            pop = 1'b0;
            hold_left--;
         end else begin
            if (phase_left == 0) begin
               style = pop_style_type'($urandom_range(0, 2));
               phase_left = $urandom_range(10, 80);
            end
            phase_left--;
            case (style)
               POP_ALWAYS: pop = 1'b1;
               POP_HALF:   pop = ($urandom_range(0, 1) == 1);
               default:    pop = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic check_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         err_count++;
         if (err_count <= MAX_REPORTS)
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   // Compare each popped word with the oldest predicted block.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && pop && !empty) begin
         if (due_blocks.size() == 0) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
               $display("%0t: result with nothing expected, column %0d row %0d",
                        $time, rsp_out_column, rsp_out_row);
         end else begin
            want = due_blocks.pop_front();
            check_field("upper_pair", want.upper_pair, rsp_upper_pair);
            check_field("lower_pair", want.lower_pair, rsp_lower_pair);
            check_field("out_column", 16'(want.out_column), 16'(rsp_out_column));
            check_field("out_row", 16'(want.out_row), 16'(rsp_out_row));
            check_field("last_of_run", 16'(want.last_of_run), 16'(rsp_last_of_run));
            check_field("frame_done", 16'(want.frame_done), 16'(rsp_frame_done));
         end
      end
   end

   initial begin
      reset = 1'b1;
      push = 1'b0;
      req_kind = KIND_PIXEL;
      req_pixel_pair = '0;
      valid = 1'b0;
      csr_index = CSR_LINE_BYTES;
      csr_data = '0;
      err_count = 0;
      burst_left = 0;
      steady = 1'b0;
      hold_req = 0;
      frame_words = 0;
      cfg_line = LINE_BYTES_RST;
      cfg_rows = FRAME_ROWS_RST;
      for (int i = 0; i < LINE_CAP; i++) begin
         above_mem[i] = 8'h00;
         centre_mem[i] = 8'h00;
      end
      win_above = 8'h00;
      win_left = 8'h00;
      win_mid = 8'h00;
      win_below = 8'h00;
      in_col = 0;
      in_row = 0;
      drain_col = 0;
      draining = 1'b0;
      pick_palette();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_wide_line();
      test_tall_frame();
      test_mid_frame_change();
      test_full_stall();
      test_random_frames();

      sender_idle();
      while (due_blocks.size() != 0) @(posedge clock);
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
